// ----- src/mvyr_pkg.sv -----
// mvyr_pkg: shared widths, angle constants, quarter-turn codes, rotator beat type
// and the arctangent table for the yaw rotator cordic cells.
// No dependencies.
`default_nettype none

package mvyr_pkg;

  // field widths
  localparam int unsigned ANG_W = 18;
  localparam int unsigned MV_W  = 16;
  localparam int unsigned DIFF_W = 19;
  localparam int unsigned D_W   = 17;
  localparam int unsigned REM_W = 16;

  // vector path: q.20 values with headroom for cordic gain, angle in degrees * 2^16
  localparam int unsigned GUARD_W = 16;
  localparam int unsigned XY_W    = 36;
  localparam int unsigned Z_W     = 24;
  localparam int unsigned TABLE_LEN = 24;

  // angles in degrees * 256
  localparam logic [DIFF_W-1:0] FULL_TURN    = 19'd92160;
  localparam logic [D_W-1:0]    QUARTER_TURN = 17'd23040;
  localparam logic [D_W-1:0]    EIGHTH_TURN  = 17'd11520;

  // gain compensation: 1/K in q.30, product rounded half up to q.4
  localparam int unsigned GAIN_W  = 30;
  localparam logic [GAIN_W-1:0] INV_GAIN = 30'd652032874;
  localparam int unsigned SPLIT_W = 18;
  localparam int unsigned ACC_W   = 68;
  localparam int unsigned OUT_SHIFT = 46;

  // quarter-turn pre-rotation codes
  typedef enum logic [1:0] {
    QTR_0   = 2'd0,
    QTR_90  = 2'd1,
    QTR_180 = 2'd2,
    QTR_270 = 2'd3
  } qtr_t;

  // one beat in the rotator chain
  typedef struct packed {
    logic signed [XY_W-1:0] x;
    logic signed [XY_W-1:0] y;
    logic signed [Z_W-1:0]  z;
  } rot_t;

  // atan(2^-i) in degrees * 2^16, rounded to nearest
  function automatic logic [Z_W-1:0] atan_deg16(input int unsigned idx);
    case (idx)
      0:  return 24'd2949120;
      1:  return 24'd1740967;
      2:  return 24'd919879;
      3:  return 24'd466945;
      4:  return 24'd234379;
      5:  return 24'd117304;
      6:  return 24'd58666;
      7:  return 24'd29335;
      8:  return 24'd14668;
      9:  return 24'd7334;
      10: return 24'd3667;
      11: return 24'd1833;
      12: return 24'd917;
      13: return 24'd458;
      14: return 24'd229;
      15: return 24'd115;
      16: return 24'd57;
      17: return 24'd29;
      18: return 24'd14;
      19: return 24'd7;
      20: return 24'd4;
      21: return 24'd2;
      22: return 24'd1;
      default: return 24'd0;
    endcase
  endfunction

endpackage

`default_nettype wire

// ----- src/movement_vector_yaw_rotate.sv -----
// movement_vector_yaw_rotate: top level of the yaw rotator, angle prep, chain of
// cordic cells and gain compensation. Depends on mvyr_pkg, mvyr_prep, mvyr_cell,
// mvyr_gain.
//
//   channel  handshake            beat fields
//   in       in_valid / in_stall  old_heading, new_heading, forward_in, side_in
//   out      out_valid / out_stall forward_out, side_out
//
// one beat accepted per cycle while in_stall is low; three angle prep stages,
// one cell per cordic iteration (at most TABLE_LEN), two gain stages.
// rst is synchronous and clears the valid bits only.
// every stage holds its own valid bit, so bubbles close up under out_stall and
// in_stall rises only once all stages are full.
`default_nettype none

module movement_vector_yaw_rotate
  import mvyr_pkg::*;
#(
  parameter int unsigned ROTATION_STAGES = 16
)
(
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    in_valid,
  output logic                         in_stall,
  input  wire logic signed [ANG_W-1:0] old_heading,
  input  wire logic signed [ANG_W-1:0] new_heading,
  input  wire logic signed [MV_W-1:0]  forward_in,
  input  wire logic signed [MV_W-1:0]  side_in,
  output logic                         out_valid,
  input  wire logic                    out_stall,
  output logic signed [MV_W-1:0]       forward_out,
  output logic signed [MV_W-1:0]       side_out
);

  localparam int unsigned NSTG =
    (ROTATION_STAGES > TABLE_LEN) ? TABLE_LEN : ROTATION_STAGES;

  logic vld [NSTG+1];
  logic rdy [NSTG+1];
  rot_t dat [NSTG+1];
  logic in_rdy;

  assign in_stall = !in_rdy;

  // angle reduction and quarter-turn pre-rotation
  mvyr_prep u_prep (
    .clk         (clk),
    .rst         (rst),
    .up_vld      (in_valid),
    .up_rdy      (in_rdy),
    .old_heading (old_heading),
    .new_heading (new_heading),
    .forward_in  (forward_in),
    .side_in     (side_in),
    .dn_vld      (vld[0]),
    .dn_rdy      (rdy[0]),
    .dn_data     (dat[0])
  );

  // cordic cell chain
  for (genvar i = 0; i < NSTG; i++) begin : g_cell
    mvyr_cell #(
      .IDX (i)
    ) u_cell (
      .clk     (clk),
      .rst     (rst),
      .up_vld  (vld[i]),
      .up_rdy  (rdy[i]),
      .up_data (dat[i]),
      .dn_vld  (vld[i+1]),
      .dn_rdy  (rdy[i+1]),
      .dn_data (dat[i+1])
    );
  end

  // gain compensation and output register
  mvyr_gain u_gain (
    .clk         (clk),
    .rst         (rst),
    .up_vld      (vld[NSTG]),
    .up_rdy      (rdy[NSTG]),
    .up_data     (dat[NSTG]),
    .dn_vld      (out_valid),
    .dn_rdy      (!out_stall),
    .forward_out (forward_out),
    .side_out    (side_out)
  );

endmodule

`default_nettype wire

// ----- src/mvyr_prep.sv -----
// mvyr_prep: heading wrap, angle difference mod 360, quarter-turn split and
// exact quarter-turn pre-rotation of the movement vector. Three pipeline stages.
// Depends on mvyr_pkg.
`default_nettype none

module mvyr_prep
  import mvyr_pkg::*;
(
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    up_vld,
  output logic                         up_rdy,
  input  wire logic signed [ANG_W-1:0] old_heading,
  input  wire logic signed [ANG_W-1:0] new_heading,
  input  wire logic signed [MV_W-1:0]  forward_in,
  input  wire logic signed [MV_W-1:0]  side_in,
  output logic                         dn_vld,
  input  wire logic                    dn_rdy,
  output rot_t                         dn_data
);

  // stage registers
  logic                     v1, v2, v3;
  logic [DIFF_W-1:0]        diff;
  logic [D_W-1:0]           dmod;
  logic signed [MV_W-1:0]   f1, s1, f2, s2;
  rot_t                     rot;

  logic r1, r2, r3;

  // bubble-collapsing ready chain
  assign r3     = !v3 || dn_rdy;
  assign r2     = !v2 || r3;
  assign r1     = !v1 || r2;
  assign up_rdy = r1;

  // stage 1: wrap each heading once and subtract
  logic [DIFF_W-1:0] ho, hn, diff_next;
  always_comb begin
    ho = {old_heading[ANG_W-1], old_heading};
    hn = {new_heading[ANG_W-1], new_heading};
    if (old_heading[ANG_W-1]) begin
      ho = ho + FULL_TURN;
    end
    if (new_heading[ANG_W-1]) begin
      hn = hn + FULL_TURN;
    end
    diff_next = hn - ho;
  end

  // stage 2: bring difference into 0..full turn, full turn excluded
  logic signed [DIFF_W:0] dx, dsel;
  logic signed [DIFF_W:0] full_s;
  always_comb begin
    dx     = $signed({diff[DIFF_W-1], diff});
    full_s = $signed({1'b0, FULL_TURN});
    if (dx >= full_s) begin
      dsel = dx - full_s;
    end else if (dx >= 0) begin
      dsel = dx;
    end else if (dx >= -full_s) begin
      dsel = dx + full_s;
    end else begin
      dsel = dx + (full_s <<< 1);
    end
  end

  // stage 3: quarter count and residual, then exact quarter rotation
  logic [D_W:0]            e, rb;
  qtr_t                    q;
  logic signed [REM_W-1:0] r;
  logic signed [XY_W-1:0]  x0, y0;
  rot_t                    rot_next;
  always_comb begin
    e = {1'b0, dmod} + {1'b0, EIGHTH_TURN};
    if (e >= ({1'b0, QUARTER_TURN} << 2)) begin
      q  = QTR_0;
      rb = e - ({1'b0, QUARTER_TURN} << 2);
    end else if (e >= ({1'b0, QUARTER_TURN} * 18'd3)) begin
      q  = QTR_270;
      rb = e - ({1'b0, QUARTER_TURN} * 18'd3);
    end else if (e >= ({1'b0, QUARTER_TURN} << 1)) begin
      q  = QTR_180;
      rb = e - ({1'b0, QUARTER_TURN} << 1);
    end else if (e >= {1'b0, QUARTER_TURN}) begin
      q  = QTR_90;
      rb = e - {1'b0, QUARTER_TURN};
    end else begin
      q  = QTR_0;
      rb = e;
    end
    r  = $signed(rb[REM_W-1:0] - EIGHTH_TURN[REM_W-1:0]);
    x0 = $signed({{(XY_W-MV_W-GUARD_W){f2[MV_W-1]}}, f2, {GUARD_W{1'b0}}});
    y0 = $signed({{(XY_W-MV_W-GUARD_W){s2[MV_W-1]}}, s2, {GUARD_W{1'b0}}});
    case (q)
      QTR_0: begin
        rot_next.x = x0;
        rot_next.y = y0;
      end
      QTR_90: begin
        rot_next.x = -y0;
        rot_next.y = x0;
      end
      QTR_180: begin
        rot_next.x = -x0;
        rot_next.y = -y0;
      end
      QTR_270: begin
        rot_next.x = y0;
        rot_next.y = -x0;
      end
      default: begin
        rot_next.x = x0;
        rot_next.y = y0;
      end
    endcase
    rot_next.z = $signed({r, 8'd0});
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (r1) v1 <= up_vld;
      if (r2) v2 <= v1;
      if (r3) v3 <= v2;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (r1 && up_vld) begin
      diff <= diff_next;
      f1   <= forward_in;
      s1   <= side_in;
    end
    if (r2 && v1) begin
      dmod <= dsel[D_W-1:0];
      f2   <= f1;
      s2   <= s1;
    end
    if (r3 && v2) begin
      rot <= rot_next;
    end
  end

  assign dn_vld  = v3;
  assign dn_data = rot;

endmodule

`default_nettype wire

// ----- src/mvyr_cell.sv -----
// mvyr_cell: one cordic micro-rotation by atan(2^-IDX) with its own beat register.
// Depends on mvyr_pkg.
`default_nettype none

module mvyr_cell
  import mvyr_pkg::*;
#(
  parameter int unsigned IDX = 0
)
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic up_vld,
  output logic      up_rdy,
  input  rot_t      up_data,
  output logic      dn_vld,
  input  wire logic dn_rdy,
  output rot_t      dn_data
);

  localparam logic [Z_W-1:0] ATAN_I = atan_deg16(IDX);

  logic vld;
  rot_t data;

  assign up_rdy = !vld || dn_rdy;

  // micro-rotation, direction from the sign of the residual angle
  logic signed [XY_W-1:0] xs, ys, dx, dy;
  rot_t                   data_next;
  always_comb begin
    xs = up_data.x;
    ys = up_data.y;
    dx = ys >>> IDX;
    dy = xs >>> IDX;
    if (!up_data.z[Z_W-1]) begin
      data_next.x = xs - dx;
      data_next.y = ys + dy;
      data_next.z = $signed(up_data.z - ATAN_I);
    end else begin
      data_next.x = xs + dx;
      data_next.y = ys - dy;
      data_next.z = $signed(up_data.z + ATAN_I);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (up_rdy) begin
      vld <= up_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (up_rdy && up_vld) begin
      data <= data_next;
    end
  end

  assign dn_vld  = vld;
  assign dn_data = data;

endmodule

`default_nettype wire

// ----- src/mvyr_gain.sv -----
// mvyr_gain: cordic gain compensation, round half up to q.4 and saturation.
// Split multiply in one stage, recombine and round in the output register stage.
// Depends on mvyr_pkg.
`default_nettype none

module mvyr_gain
  import mvyr_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   up_vld,
  output logic                        up_rdy,
  input  rot_t                        up_data,
  output logic                        dn_vld,
  input  wire logic                   dn_rdy,
  output logic signed [MV_W-1:0]      forward_out,
  output logic signed [MV_W-1:0]      side_out
);

  localparam int unsigned HI_W = XY_W - SPLIT_W;
  localparam int unsigned PH_W = HI_W + GAIN_W + 1;
  localparam int unsigned PL_W = SPLIT_W + GAIN_W;
  localparam int unsigned SH_W = ACC_W - OUT_SHIFT;
  localparam logic [ACC_W-1:0] ROUND_HALF = {{(ACC_W-1){1'b0}}, 1'b1} << (OUT_SHIFT - 1);
  localparam logic signed [GAIN_W:0] GAIN_S = $signed({1'b0, INV_GAIN});

  logic va, vb, ra, rb;

  assign rb     = !vb || dn_rdy;
  assign ra     = !va || rb;
  assign up_rdy = ra;

  logic signed [XY_W-1:0] lane_in [2];
  logic signed [PH_W-1:0] ph [2];
  logic [PL_W-1:0]        pl [2];
  logic signed [MV_W-1:0] res [2];
  logic signed [PH_W-1:0] ph_next [2];
  logic [PL_W-1:0]        pl_next [2];
  logic signed [MV_W-1:0] res_next [2];

  assign lane_in[0] = up_data.x;
  assign lane_in[1] = up_data.y;

  for (genvar ln = 0; ln < 2; ln++) begin : g_lane
    // partial products of the high signed and low unsigned halves
    logic signed [HI_W-1:0] xh;
    logic [SPLIT_W-1:0]     xl;
    assign xh = lane_in[ln][XY_W-1:SPLIT_W];
    assign xl = lane_in[ln][SPLIT_W-1:0];
    assign ph_next[ln] = xh * GAIN_S;
    assign pl_next[ln] = xl * INV_GAIN;

    // recombine, round, saturate
    logic [ACC_W-1:0] acc;
    logic [SH_W-1:0]  sh;
    always_comb begin
      acc = {{(ACC_W-PH_W-SPLIT_W){ph[ln][PH_W-1]}}, ph[ln], {SPLIT_W{1'b0}}}
            + {{(ACC_W-PL_W){1'b0}}, pl[ln]} + ROUND_HALF;
      sh  = acc[ACC_W-1:OUT_SHIFT];
      if (sh[SH_W-1:MV_W-1] == {(SH_W-MV_W+1){1'b0}}
          || sh[SH_W-1:MV_W-1] == {(SH_W-MV_W+1){1'b1}}) begin
        res_next[ln] = $signed(sh[MV_W-1:0]);
      end else if (sh[SH_W-1]) begin
        res_next[ln] = $signed({1'b1, {(MV_W-1){1'b0}}});
      end else begin
        res_next[ln] = $signed({1'b0, {(MV_W-1){1'b1}}});
      end
    end

    always_ff @(posedge clk) begin
      if (ra && up_vld) begin
        ph[ln] <= ph_next[ln];
        pl[ln] <= pl_next[ln];
      end
      if (rb && va) begin
        res[ln] <= res_next[ln];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
      vb <= 1'b0;
    end else begin
      if (ra) va <= up_vld;
      if (rb) vb <= va;
    end
  end

  assign dn_vld      = vb;
  assign forward_out = res[0];
  assign side_out    = res[1];

endmodule

`default_nettype wire
